### hdl/wss_pkg.sv
// ----------------------------------------------------------------------------
// wss_pkg
// Shared codes, register indexes and reset values of the LED strip serializer.
// ----------------------------------------------------------------------------
package wss_pkg;

  // Default number of pixel entries.
  localparam int unsigned LedCapDefault = 64;

  // Pixel word width (green, red, blue).
  localparam int unsigned PixelW = 24;

  // Command codes
  localparam logic [1:0] CmdSetPixel = 2'd0;
  localparam logic [1:0] CmdRefresh  = 2'd1;
  localparam logic [1:0] CmdClear    = 2'd2;
  localparam logic [1:0] CmdTick     = 2'd3;

  // Status codes
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StRange = 2'd1;
  localparam logic [1:0] StBusy  = 2'd2;

  // Register indexes
  localparam logic [2:0] RegStripLength = 3'd0;
  localparam logic [2:0] RegZeroHigh    = 3'd1;
  localparam logic [2:0] RegZeroLow     = 3'd2;
  localparam logic [2:0] RegOneHigh     = 3'd3;
  localparam logic [2:0] RegOneLow      = 3'd4;

  // Register reset values
  localparam logic [6:0] StripLengthRst = 7'd64;
  localparam logic [7:0] ZeroHighRst    = 8'd3;
  localparam logic [7:0] ZeroLowRst     = 8'd9;
  localparam logic [7:0] OneHighRst     = 8'd7;
  localparam logic [7:0] OneLowRst      = 8'd5;

endpackage

### hdl/ws2812_strip_serializer.sv
// ----------------------------------------------------------------------------
// ws2812_strip_serializer
// Pixel store plus single-wire serializer for a chain of smart RGB LEDs.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake              | Payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid_i / in_ready_o| command_i, led_index_i, red_i, green_i,
//          |                        | blue_i
//  out     | out_valid_o/out_ready_i| line_level_o, busy_res_o, status_o,
//          |                        | frame_done_o
//  cfg     | cfg_we_i (no wait)     | cfg_index_i, cfg_data_i
//
//  Cycles: one item per cycle; its result appears in the output register the
//  cycle after it is accepted. The only loop is the bit/tick counter update,
//  a 9-bit add and compare.
//  Reset: all control state and the pixel valid bits clear at once, so no
//  clearing pass is needed and items are taken from the first cycle.
//  Stalls: in_ready_o drops only while a result sits in the output register
//  and out_ready_i is low; a stall on either side changes no state.
//
//  Pixel store: a one-read, one-write memory with registered read data, plus
//  one valid bit per entry. An entry that is not valid reads as zero, so a
//  clear command only drops the valid bits of the entries in use.
//  During a frame the read port fetches the pixel after the current one; the
//  word is moved into the current-pixel register when the last bit ends.
//  At frame start entry 0 is read in the accept cycle and used straight from
//  the read register until it is copied in the cycle after the accept.
// ----------------------------------------------------------------------------
module ws2812_strip_serializer
  import wss_pkg::*;
#(
  parameter int unsigned LedCap = LedCapDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // command / tick items
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] command_i,
  input  logic [7:0] led_index_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  // result items
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       line_level_o,
  output logic       busy_res_o,
  output logic [1:0] status_o,
  output logic       frame_done_o,
  // configuration writes
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  // The 7-bit length register never reaches entries beyond 127.
  localparam int unsigned Depth  = (LedCap < 128) ? LedCap : 128;
  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [7:0]  DepthL = 8'(Depth);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [6:0] len_cfg_q;
  logic [7:0] zero_hi_q, zero_lo_q, one_hi_q, one_lo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_cfg_q <= StripLengthRst;
      zero_hi_q <= ZeroHighRst;
      zero_lo_q <= ZeroLowRst;
      one_hi_q  <= OneHighRst;
      one_lo_q  <= OneLowRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegStripLength: len_cfg_q <= cfg_data_i[6:0];
        RegZeroHigh:    zero_hi_q <= cfg_data_i;
        RegZeroLow:     zero_lo_q <= cfg_data_i;
        RegOneHigh:     one_hi_q  <= cfg_data_i;
        RegOneLow:      one_lo_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective strip length: min(strip_length, entries)
  logic [7:0] eff_len;
  assign eff_len = ({1'b0, len_cfg_q} < DepthL) ? {1'b0, len_cfg_q} : DepthL;

  // --------------------------------------------------------------------------
  // Frame state
  // --------------------------------------------------------------------------
  logic             sending_q, sending_d;
  logic [AddrW-1:0] pix_pos_q, pix_pos_d;
  logic [4:0]       bit_pos_q, bit_pos_d;
  logic [8:0]       tick_q, tick_d;
  logic             load_pend_q, load_pend_d;
  logic [PixelW-1:0] cur_q, cur_d;

  // pixel store
  logic [PixelW-1:0] mem_q [Depth];
  logic [Depth-1:0]  valid_q, valid_d;
  logic [PixelW-1:0] rd_data_q;
  logic              rd_vld_q;
  logic [AddrW-1:0]  rd_addr;
  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  logic [PixelW-1:0] wr_data;

  // output register
  logic       out_valid_q;
  logic       line_q, line_d;
  logic       busy_q, busy_d;
  logic [1:0] status_q, status_d;
  logic       done_q, done_d;

  logic accept;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // --------------------------------------------------------------------------
  // Current slot level
  // --------------------------------------------------------------------------
  logic [PixelW-1:0] rd_word, cur_word;
  logic              cur_bit;
  logic [7:0]        hi_raw, lo_raw, hi_t, lo_t;
  logic [8:0]        span, tick_inc;
  logic              cur_level;

  assign rd_word  = rd_vld_q ? rd_data_q : '0;
  assign cur_word = load_pend_q ? rd_word : cur_q;
  assign cur_bit  = cur_word[5'd23 - bit_pos_q];
  assign hi_raw   = cur_bit ? one_hi_q : zero_hi_q;
  assign lo_raw   = cur_bit ? one_lo_q : zero_lo_q;
  // a zero timing value counts as one tick
  assign hi_t     = (hi_raw == 8'd0) ? 8'd1 : hi_raw;
  assign lo_t     = (lo_raw == 8'd0) ? 8'd1 : lo_raw;
  assign span     = {1'b0, hi_t} + {1'b0, lo_t};
  assign tick_inc = tick_q + 9'd1;
  assign cur_level = (tick_q < {1'b0, hi_t});

  // next pixel to prefetch while a frame runs
  logic [7:0] next_pos;
  logic       start_frame, clear_cmd;
  assign next_pos = 8'(pix_pos_q) + 8'd1;

  // --------------------------------------------------------------------------
  // Item processing
  // --------------------------------------------------------------------------
  always_comb begin
    sending_d   = sending_q;
    pix_pos_d   = pix_pos_q;
    bit_pos_d   = bit_pos_q;
    tick_d      = tick_q;
    load_pend_d = 1'b0;
    cur_d       = load_pend_q ? rd_word : cur_q;
    valid_d     = valid_q;
    wr_en       = 1'b0;
    wr_addr     = led_index_i[AddrW-1:0];
    wr_data     = {green_i, red_i, blue_i};
    start_frame = 1'b0;
    clear_cmd   = 1'b0;
    line_d      = 1'b0;
    busy_d      = 1'b0;
    status_d    = StOk;
    done_d      = 1'b0;

    if (accept) begin
      if (command_i == CmdTick) begin
        if (sending_q) begin
          busy_d = 1'b1;
          line_d = cur_level;
          tick_d = tick_inc;
          if (tick_inc >= span) begin
            tick_d = '0;
            if (bit_pos_q >= 5'd23) begin
              bit_pos_d = '0;
              if (next_pos >= eff_len) begin
                sending_d = 1'b0;
                pix_pos_d = '0;
                done_d    = 1'b1;
              end else begin
                pix_pos_d = pix_pos_q + AddrW'(1);
                cur_d     = rd_word;
              end
            end else begin
              bit_pos_d = bit_pos_q + 5'd1;
            end
          end
        end
      end else if (sending_q) begin
        busy_d   = 1'b1;
        status_d = StBusy;
        line_d   = cur_level;
      end else if (command_i == CmdSetPixel) begin
        if (led_index_i < eff_len) begin
          wr_en = 1'b1;
          valid_d[led_index_i[AddrW-1:0]] = 1'b1;
        end else begin
          status_d = StRange;
        end
      end else begin
        if (command_i == CmdClear) begin
          clear_cmd = 1'b1;
          for (int i = 0; i < int'(Depth); i++) begin
            if (8'(i) < eff_len) valid_d[i] = 1'b0;
          end
        end
        if (eff_len != 8'd0) begin
          start_frame = 1'b1;
          sending_d   = 1'b1;
          pix_pos_d   = '0;
          bit_pos_d   = '0;
          tick_d      = '0;
          load_pend_d = 1'b1;
          busy_d      = 1'b1;
        end
      end
    end
  end

  // read entry 0 while idle and at frame start, else the pixel after the current one
  always_comb begin
    if (start_frame || !sending_q) begin
      rd_addr = '0;
    end else if (next_pos < DepthL) begin
      rd_addr = next_pos[AddrW-1:0];
    end else begin
      rd_addr = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Pixel memory
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
    // a clear in the same cycle drops entry 0
    rd_vld_q  <= valid_q[rd_addr] && !clear_cmd;
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q   <= 1'b0;
      pix_pos_q   <= '0;
      bit_pos_q   <= '0;
      tick_q      <= '0;
      load_pend_q <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sending_q   <= sending_d;
      pix_pos_q   <= pix_pos_d;
      bit_pos_q   <= bit_pos_d;
      tick_q      <= tick_d;
      load_pend_q <= load_pend_d;
      valid_q     <= valid_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (accept) begin
      line_q   <= line_d;
      busy_q   <= busy_d;
      status_q <= status_d;
      done_q   <= done_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign line_level_o = line_q;
  assign busy_res_o   = busy_q;
  assign status_o     = status_q;
  assign frame_done_o = done_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // a high line or a busy rejection only comes from a running frame
  a_line_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (line_level_o || status_o == StBusy) |-> busy_res_o)
    else $error("line high or busy status without busy flag");

  // the frame ends on the last tick it reports
  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && done_d |=> !sending_q)
    else $error("frame still sending after frame_done");

  // entry 0 is taken from the read register only right after a frame start
  a_load_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_pend_q |-> sending_q && pix_pos_q == '0 && $past(start_frame))
    else $error("pixel load pending outside frame start");

  // the frame position never passes the stored entries
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sending_q |-> 8'(pix_pos_q) < DepthL && bit_pos_q <= 5'd23)
    else $error("frame position out of range");

endmodule
